>>> hw/rtl/refcounted_page_allocator_assert.svh
// assertion macros of the page allocator datapath
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define RPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rpa_pkg.sv
// types, sizes and codes of the refcounted page allocator
package rpa_pkg;

  // memory geometry
  localparam int unsigned NUM_PAGES  = 32768;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_W     = $clog2(NUM_PAGES);
  localparam int unsigned OFF_W      = $clog2(PAGE_BYTES);
  localparam int unsigned CNT_W      = PAGE_W + 1;

  // field widths
  localparam int unsigned OPC_W  = 3;
  localparam int unsigned ADDR_W = 27;
  localparam int unsigned RC_W   = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FUP_W  = 15;

  // page number field of a byte address and a width that holds every compare
  localparam int unsigned PG_FIELD_W = ADDR_W - OFF_W;
  localparam int unsigned CMP_A      = (PG_FIELD_W > FUP_W) ? PG_FIELD_W : FUP_W;
  localparam int unsigned CMP_W      = ((CMP_A > CNT_W) ? CMP_A : CNT_W) + 1;

  // register port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FUP = '0;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_GET   = 3'd2,
    OP_SET   = 3'd3,
    OP_INIT  = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BADADDR  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_EXEC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep;
    logic sweep_init;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_init;
    logic sweep_last;
    logic out_stall;
  } dp_status_t;

endpackage

>>> hw/rtl/rpa_if.sv
// request and response channels of the page allocator

// request word: operation, byte address and new count
interface rpa_req_if;
  import rpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [ADDR_W-1:0] byte_address;
  logic [RC_W-1:0]   new_refcount;

  modport source (output valid, output opcode, output byte_address, output new_refcount,
                  input ready);
  modport sink   (input valid, input opcode, input byte_address, input new_refcount,
                  output ready);
endinterface

// response word: page address, count and status
interface rpa_rsp_if;
  import rpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] page_address;
  logic [RC_W-1:0]   refcount;
  logic [STAT_W-1:0] status;

  modport source (output valid, output page_address, output refcount, output status,
                  input ready);
  modport sink   (input valid, input page_address, input refcount, input status,
                  output ready);
endinterface

>>> hw/rtl/refcounted_page_allocator.sv
// top level of the refcounted page allocator
//
// Requests arrive on req_i (opcode, byte_address, new_refcount) with a
// valid/ready handshake; each request gives exactly one response word on
// rsp_o (page_address, refcount, status). first_usable_page is written
// through the APB-style port at byte address 0 and read back there.
// For alloc, free, get and set the request is accepted and its count table
// and stack top are read in S_IDLE; the operation is then executed and loaded
// into the response register in S_EXEC. A new request is not accepted before
// the last one is executed, set by the registered read of the two single-write
// rams before the read-modify-write.
// Init sweeps both rams one entry a cycle, in S_SWEEP, before it executes.
// After reset a clearing pass zeroes every entry of the count table;
// req_i.ready stays low until it ends, register writes are taken as ever.
// A stalled receiver holds the response in its register; one more request
// is accepted and waits, unexecuted, until the response register frees up.
module refcounted_page_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rpa_req_if.sink                           req_i,
  rpa_rsp_if.source                         rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpa_pkg::PADDR_W-1:0]       paddr,
  input  logic [rpa_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rpa_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rpa_pkg::*;

  ctrl_cmd_t             cmd;
  dp_status_t            dp_st;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_we;
  logic [FUP_W-1:0]      fup;

  // register decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_FUP);

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_FUP) begin
      prdata = APB_DATA_W'(fup);
    end
  end

  // sequencer
  rpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .st_i       (dp_st),
    .cmd_o      (cmd)
  );

  // datapath
  rpa_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (dp_st),
    .opcode_i       (req_i.opcode),
    .byte_address_i (req_i.byte_address),
    .new_refcount_i (req_i.new_refcount),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[FUP_W-1:0]),
    .fup_o          (fup),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .page_address_o (rsp_o.page_address),
    .refcount_o     (rsp_o.refcount),
    .rsp_status_o   (rsp_o.status)
  );

endmodule

>>> hw/rtl/rpa_ram.sv
// generic simple dual-port ram with registered read
module rpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rpa_ctrl.sv
// sequencer of the page allocator: clearing pass, accept, sweep, execute
module rpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rpa_pkg::dp_status_t st_i,
  output rpa_pkg::ctrl_cmd_t  cmd_o
);
  import rpa_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (st_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = st_i.in_init ? S_SWEEP : S_EXEC;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_init = 1'b1;
        if (st_i.sweep_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!st_i.out_stall) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

>>> hw/rtl/rpa_dpath.sv
// datapath of the page allocator: count table, free stack and result register
module rpa_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rpa_pkg::ctrl_cmd_t             cmd_i,
  output rpa_pkg::dp_status_t            st_o,
  // request payload
  input  logic [rpa_pkg::OPC_W-1:0]      opcode_i,
  input  logic [rpa_pkg::ADDR_W-1:0]     byte_address_i,
  input  logic [rpa_pkg::RC_W-1:0]       new_refcount_i,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [rpa_pkg::FUP_W-1:0]      cfg_wdata_i,
  output logic [rpa_pkg::FUP_W-1:0]      fup_o,
  // response
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rpa_pkg::ADDR_W-1:0]     page_address_o,
  output logic [rpa_pkg::RC_W-1:0]       refcount_o,
  output logic [rpa_pkg::STAT_W-1:0]     rsp_status_o
);
  import rpa_pkg::*;

  `include "refcounted_page_allocator_assert.svh"

  // captured request
  logic [OPC_W-1:0]  op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [RC_W-1:0]   newcnt_q;

  // control state
  logic [FUP_W-1:0]  fup_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PAGE_W-1:0] sweep_idx_q, sweep_idx_d;
  logic              out_valid_q;

  // result register
  logic [ADDR_W-1:0] out_addr_q, res_addr;
  logic [RC_W-1:0]   out_rc_q, res_rc;
  status_e           out_st_q, res_st;

  // ram ports
  logic              rc_we, st_we;
  logic [PAGE_W-1:0] rc_waddr, st_waddr, rc_raddr, st_raddr;
  logic [RC_W-1:0]   rc_wdata, rc_rdata;
  logic [PAGE_W-1:0] st_wdata, st_rdata;

  // address decode
  logic [CMP_W-1:0]  page_ext, in_page_ext, fup_ext, fill_ext;
  logic [PAGE_W-1:0] page_idx;
  logic              page_in_range, free_ok, stack_full, stack_empty;
  logic [CNT_W-1:0]  init_count;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= opcode_i;
      addr_q   <= byte_address_i;
      newcnt_q <= new_refcount_i;
    end
  end

  // configuration register, stack fill count, sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fup_q       <= '0;
      count_q     <= '0;
      sweep_idx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        fup_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      sweep_idx_q <= sweep_idx_d;
    end
  end

  assign sweep_idx_d = !cmd_i.sweep ? sweep_idx_q :
                       st_o.sweep_last ? '0 : sweep_idx_q + PAGE_W'(1);

  // page numbers and range checks
  assign page_ext      = CMP_W'(addr_q[ADDR_W-1:OFF_W]);
  assign in_page_ext   = CMP_W'(byte_address_i[ADDR_W-1:OFF_W]);
  assign fup_ext       = CMP_W'(fup_q);
  assign fill_ext      = fup_ext + CMP_W'(sweep_idx_q);
  assign page_idx      = page_ext[PAGE_W-1:0];
  assign page_in_range = page_ext < CMP_W'(NUM_PAGES);
  assign free_ok       = (addr_q[OFF_W-1:0] == '0) && (page_ext >= fup_ext) && page_in_range;
  assign stack_full    = count_q == CNT_W'(NUM_PAGES);
  assign stack_empty   = count_q == '0;
  assign init_count    = (fup_ext < CMP_W'(NUM_PAGES)) ?
                         CNT_W'(CMP_W'(NUM_PAGES) - fup_ext) : '0;

  // ram reads are issued with the accepted request
  assign rc_raddr = in_page_ext[PAGE_W-1:0];
  assign st_raddr = PAGE_W'(count_q - CNT_W'(1));

  // operation execute and ram writes
  always_comb begin
    rc_we    = 1'b0;
    rc_waddr = sweep_idx_q;
    rc_wdata = '0;
    st_we    = 1'b0;
    st_waddr = sweep_idx_q;
    st_wdata = fill_ext[PAGE_W-1:0];
    count_d  = count_q;
    res_addr = '0;
    res_rc   = '0;
    res_st   = ST_OK;
    if (cmd_i.sweep) begin
      rc_we = 1'b1;
      st_we = cmd_i.sweep_init;
    end
    if (cmd_i.exec) begin
      unique case (op_q)
        OP_ALLOC: begin
          if (stack_empty) begin
            res_st = ST_OOM;
          end else begin
            count_d  = count_q - CNT_W'(1);
            rc_we    = 1'b1;
            rc_waddr = st_rdata;
            rc_wdata = RC_W'(1);
            res_addr = ADDR_W'(st_rdata) << OFF_W;
          end
        end
        OP_FREE: begin
          if (!free_ok) begin
            res_st = ST_BADADDR;
          end else begin
            rc_we    = 1'b1;
            rc_waddr = page_idx;
            if (rc_rdata > RC_W'(1)) begin
              rc_wdata = rc_rdata - RC_W'(1);
            end else if (stack_full) begin
              res_st = ST_OVERFLOW;
            end else begin
              st_we    = 1'b1;
              st_waddr = count_q[PAGE_W-1:0];
              st_wdata = page_idx;
              count_d  = count_q + CNT_W'(1);
            end
          end
        end
        OP_GET: begin
          if (!page_in_range) begin
            res_st = ST_BADADDR;
          end else begin
            res_rc = rc_rdata;
          end
        end
        OP_SET: begin
          if (!page_in_range) begin
            res_st = ST_BADADDR;
          end else begin
            rc_we    = 1'b1;
            rc_waddr = page_idx;
            rc_wdata = newcnt_q;
          end
        end
        OP_INIT: begin
          count_d = init_count;
        end
        default: begin
        end
      endcase
    end
  end

  // response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_addr_q <= res_addr;
      out_rc_q   <= res_rc;
      out_st_q   <= res_st;
    end
  end

  // reference count table
  rpa_ram #(
    .WIDTH (RC_W),
    .DEPTH (NUM_PAGES)
  ) u_rc_ram (
    .clk_i   (clk_i),
    .we_i    (rc_we),
    .waddr_i (rc_waddr),
    .wdata_i (rc_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (rc_raddr),
    .rdata_o (rc_rdata)
  );

  // free page stack
  rpa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // status to the sequencer
  assign st_o.in_init    = opcode_i == OP_INIT;
  assign st_o.sweep_last = sweep_idx_q == PAGE_W'(NUM_PAGES - 1);
  assign st_o.out_stall  = out_valid_q && !out_ready_i;

  assign fup_o          = fup_q;
  assign out_valid_o    = out_valid_q;
  assign page_address_o = out_addr_q;
  assign refcount_o     = out_rc_q;
  assign rsp_status_o   = out_st_q;

  // checks
  `RPA_ASSERT(a_count_range, count_q <= CNT_W'(NUM_PAGES), "free count beyond stack depth")
  `RPA_ASSERT(a_cmd_excl, !(cmd_i.exec && cmd_i.sweep), "execute during sweep")
  `RPA_ASSERT_NXT(a_alloc_pop, cmd_i.exec && (op_q == OP_ALLOC) && !stack_empty,
                  count_q == $past(count_q) - CNT_W'(1), "alloc did not pop the stack")
  `RPA_ASSERT_IMP(a_valid_src, $rose(out_valid_q), $past(cmd_i.exec),
                  "response raised without execute")
  `RPA_ASSERT_IMP(a_no_drop, cmd_i.exec, !st_o.out_stall, "response overwritten while stalled")

endmodule
